@@ rtl/pwls_pkg.sv @@
package pwls_pkg;

    localparam int LIBRARY_DEPTH = 1024;
    localparam int ADDR_W        = $clog2(LIBRARY_DEPTH);
    localparam int IDX_W         = ADDR_W + 1;
    localparam int MAX_MATCHES   = 64;
    localparam int CNT_W         = $clog2(MAX_MATCHES + 1);

    localparam int SLOT_W        = 10;
    localparam int MASS_W        = 32;
    localparam int TOL_W         = 10;
    localparam int COUNT_W       = 11;

    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 11;

    // tolerance is in tenths of ppm
    localparam int PPM_SCALE     = 10000000;
    localparam int SCALE_W       = 24;
    localparam int PROD_W        = MASS_W + SCALE_W;

    localparam logic [TOL_W-1:0]     TOL_RESET     = TOL_W'(50);

    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LIB_COUNT = CFG_IDX_W'(1);

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [SLOT_W-1:0] entry_slot;
        logic [MASS_W-1:0] mass_value;
    } t_in_item;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] match_slot;
        logic              last;
        logic              truncated;
    } t_out_item;

endpackage

@@ rtl/ppm_window_library_search_unit.sv @@
// A load leaves the block idle, so a new transaction is accepted the next cycle.
// A query runs binary-search probes, each an address, memory read, window
// multiply and compare step, then checks neighbors of the hit, left then right,
// each a bound check, read, multiply and compare, and ends in a finish state.
// One query is in flight at a time; results leave through an output register,
// and while a result waits on i_out_stall the query holds until it can leave.
// Reset (synchronous, active low) restores tolerance 50 and count 0; library
// contents are undefined until loaded.
module ppm_window_library_search_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  pwls_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output pwls_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pwls_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pwls_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRCH = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_NEXT = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    localparam logic [1:0] PH_SRCH  = 2'd0;
    localparam logic [1:0] PH_LEFT  = 2'd1;
    localparam logic [1:0] PH_RIGHT = 2'd2;

    localparam int IW = pwls_pkg::IDX_W;
    localparam int AW = pwls_pkg::ADDR_W;
    localparam int PW = pwls_pkg::PROD_W;

    logic [pwls_pkg::MASS_W-1:0] r_mem [pwls_pkg::LIBRARY_DEPTH];
    logic [pwls_pkg::MASS_W-1:0] r_rd;

    logic [2:0]                   r_state, n_state;
    logic [1:0]                   r_phase, n_phase;
    logic [IW-1:0]                r_lo, n_lo;
    logic [IW-1:0]                r_hix, n_hix;
    logic [IW-1:0]                r_idx, n_idx;
    logic [IW-1:0]                r_mid, n_mid;
    logic [AW-1:0]                r_pend, n_pend;
    logic                         r_found, n_found;
    logic [pwls_pkg::CNT_W-1:0]   r_n, n_n;
    logic                         r_ov, n_ov;
    pwls_pkg::t_out_item          r_out, n_out;

    logic [pwls_pkg::TOL_W-1:0]   r_tol;
    logic [pwls_pkg::COUNT_W-1:0] r_count;

    logic [pwls_pkg::MASS_W-1:0]  r_q;
    logic [PW-1:0]                r_qs;
    logic [PW-1:0]                r_phi;
    logic [PW-1:0]                r_plo;
    logic                         r_ge;

    logic                         in_acc;
    logic                         mem_we;
    logic                         out_free;
    logic                         hit;
    logic [IW-1:0]                eff_count;
    logic [IW:0]                  mid_sum;
    logic [pwls_pkg::SCALE_W-1:0] scale_hi;
    logic [pwls_pkg::SCALE_W-1:0] scale_lo;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    assign in_acc = i_in_valid && !o_in_stall;
    assign mem_we = in_acc && (i_in_data.mode == pwls_pkg::MODE_LOAD) &&
                    (32'(i_in_data.entry_slot) < 32'(pwls_pkg::LIBRARY_DEPTH));

    assign eff_count = (32'(r_count) > 32'(pwls_pkg::LIBRARY_DEPTH)) ?
                       IW'(pwls_pkg::LIBRARY_DEPTH) : IW'(r_count);

    // floor((lo + hi) / 2) with hi kept exclusive
    assign mid_sum = (IW+1)'(r_lo) + (IW+1)'(r_hix) - (IW+1)'(1);

    // |q-e|*S <= e*T  <=>  q*S <= e*(S+T) when q >= e, else e*(S-T) <= q*S
    assign scale_hi = pwls_pkg::SCALE_W'(pwls_pkg::PPM_SCALE) + pwls_pkg::SCALE_W'(r_tol);
    assign scale_lo = pwls_pkg::SCALE_W'(pwls_pkg::PPM_SCALE) - pwls_pkg::SCALE_W'(r_tol);
    assign hit      = r_ge ? (r_qs <= r_phi) : (r_plo <= r_qs);

    assign out_free = !r_ov || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[AW'(i_in_data.entry_slot)] <= i_in_data.mass_value;
        end
        r_rd <= r_mem[r_idx[AW-1:0]];
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_lo    = r_lo;
        n_hix   = r_hix;
        n_idx   = r_idx;
        n_mid   = r_mid;
        n_pend  = r_pend;
        n_found = r_found;
        n_n     = r_n;
        n_ov    = r_ov;
        n_out   = r_out;

        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in_data.mode == pwls_pkg::MODE_QUERY)) begin
                    n_lo    = '0;
                    n_hix   = eff_count;
                    n_found = 1'b0;
                    n_pend  = '0;
                    n_n     = '0;
                    n_phase = PH_SRCH;
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                if (r_lo < r_hix) begin
                    n_idx   = mid_sum[IW:1];
                    n_state = S_READ;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_READ: n_state = S_MUL;
            S_MUL:  n_state = S_CMP;
            S_CMP: begin
                if (r_phase == PH_SRCH) begin
                    if (hit) begin
                        n_found = 1'b1;
                        n_pend  = AW'(r_idx);
                        n_n     = pwls_pkg::CNT_W'(1);
                        n_mid   = r_idx;
                        n_idx   = r_idx - IW'(1);
                        n_phase = PH_LEFT;
                        n_state = S_NEXT;
                    end else begin
                        if (r_ge) begin
                            n_lo = r_idx + IW'(1);
                        end else begin
                            n_hix = r_idx;
                        end
                        n_state = S_SRCH;
                    end
                end else if (hit) begin
                    // previous match is not the final one; hold here until it can leave
                    if (out_free) begin
                        n_ov             = 1'b1;
                        n_out.found      = 1'b1;
                        n_out.match_slot = pwls_pkg::SLOT_W'(r_pend);
                        n_out.last       = 1'b0;
                        n_out.truncated  = 1'b0;
                        n_pend           = AW'(r_idx);
                        n_n              = r_n + pwls_pkg::CNT_W'(1);
                        n_idx            = (r_phase == PH_LEFT) ? r_idx - IW'(1)
                                                                : r_idx + IW'(1);
                        n_state          = S_NEXT;
                    end
                end else if (r_phase == PH_LEFT) begin
                    n_phase = PH_RIGHT;
                    n_idx   = r_mid + IW'(1);
                    n_state = S_NEXT;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_NEXT: begin
                // left walk past index 0 wraps to all ones, which fails the bound
                if ((r_idx < eff_count) &&
                    (32'(r_n) < 32'(pwls_pkg::MAX_MATCHES))) begin
                    n_state = S_READ;
                end else if (r_phase == PH_LEFT) begin
                    n_phase = PH_RIGHT;
                    n_idx   = r_mid + IW'(1);
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_ov             = 1'b1;
                    n_out.found      = r_found;
                    n_out.match_slot = pwls_pkg::SLOT_W'(r_pend);
                    n_out.last       = 1'b1;
                    n_out.truncated  = r_found &&
                                       (32'(r_n) >= 32'(pwls_pkg::MAX_MATCHES));
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_tol   <= pwls_pkg::TOL_RESET;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    pwls_pkg::CFG_TOLERANCE: r_tol   <= i_cfg_data[pwls_pkg::TOL_W-1:0];
                    pwls_pkg::CFG_LIB_COUNT: r_count <= i_cfg_data[pwls_pkg::COUNT_W-1:0];
                    default: ;
                endcase
            end
        end

        r_phase <= n_phase;
        r_lo    <= n_lo;
        r_hix   <= n_hix;
        r_idx   <= n_idx;
        r_mid   <= n_mid;
        r_pend  <= n_pend;
        r_found <= n_found;
        r_n     <= n_n;
        r_out   <= n_out;

        if (in_acc) begin
            r_q  <= i_in_data.mass_value;
            r_qs <= PW'(i_in_data.mass_value) * PW'(pwls_pkg::PPM_SCALE);
        end

        r_phi <= PW'(r_rd) * PW'(scale_hi);
        r_plo <= PW'(r_rd) * PW'(scale_lo);
        r_ge  <= (r_q >= r_rd);
    end

endmodule

@@ rtl/pwls_checker.sv @@
module pwls_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                o_in_stall,
    input  pwls_pkg::t_in_item                  i_in_data,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  pwls_pkg::t_out_item                 o_out_data
);

    logic in_acc;

    assign in_acc = i_in_valid && !o_in_stall;

    // a query occupies the block at least into the next cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in_data.mode == pwls_pkg::MODE_QUERY) |=> o_in_stall)
        else $error("query accepted but block not busy next cycle");

    // a load completes at once
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in_data.mode == pwls_pkg::MODE_LOAD) |=> !o_in_stall)
        else $error("load left the block busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or dropped");

    // a miss is always a lone, final, clean result
    a_miss_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.found |->
            o_out_data.last && !o_out_data.truncated && (o_out_data.match_slot == '0))
        else $error("malformed no-match result");

    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.truncated |-> o_out_data.last)
        else $error("truncated flag on a non-final result");

endmodule

bind ppm_window_library_search_unit pwls_checker u_pwls_checker (.*);
